// ----- sv/draw_task_area_histogram_assert.svh -----
// assertion macros used by the histogram controller
`ifndef DRAW_TASK_AREA_HISTOGRAM_ASSERT_SVH
`define DRAW_TASK_AREA_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DTAH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DTAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dtah_pkg.sv -----
package dtah_pkg;

  // default sizing of the store
  localparam int DTAH_SCENES    = 16;
  localparam int DTAH_TYPES     = 13;
  localparam int DTAH_RENDERERS = 3;

  // size classes are fixed at eight
  localparam int BUCKETS  = 8;
  localparam int BUCKET_W = 3;

  // request kinds
  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_BEGIN = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_TAG   = 3'd3;
  localparam logic [2:0] KIND_EXEC  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  // size class limits, inclusive upper bounds
  localparam logic [32:0] CLS_LIM1 = 33'd64;
  localparam logic [32:0] CLS_LIM2 = 33'd256;
  localparam logic [32:0] CLS_LIM3 = 33'd1024;
  localparam logic [32:0] CLS_LIM4 = 33'd4096;
  localparam logic [32:0] CLS_LIM5 = 33'd16384;
  localparam logic [32:0] CLS_LIM6 = 33'd65536;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic look_en;
    logic post_en;
    logic sweep_en;
  } dtah_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       sweep_last;
  } dtah_status_t;

  // power-of-four size class of a pixel count
  function automatic logic [2:0] size_class_of(input logic [32:0] px);
    logic [2:0] cls;
    if (px == 33'd0) cls = 3'd0;
    else if (px <= CLS_LIM1) cls = 3'd1;
    else if (px <= CLS_LIM2) cls = 3'd2;
    else if (px <= CLS_LIM3) cls = 3'd3;
    else if (px <= CLS_LIM4) cls = 3'd4;
    else if (px <= CLS_LIM5) cls = 3'd5;
    else if (px <= CLS_LIM6) cls = 3'd6;
    else cls = 3'd7;
    return cls;
  endfunction

endpackage

// ----- sv/dtah_datapath.sv -----
module dtah_datapath #(
  parameter int SCENES    = dtah_pkg::DTAH_SCENES,
  parameter int TYPES     = dtah_pkg::DTAH_TYPES,
  parameter int RENDERERS = dtah_pkg::DTAH_RENDERERS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtah_pkg::dtah_cmd_t    cmd,
  output dtah_pkg::dtah_status_t status,
  input  logic [2:0]             in_kind,
  input  logic [7:0]             in_scene,
  input  logic [7:0]             in_draw_type,
  input  logic [7:0]             in_renderer,
  input  logic signed [15:0]     in_left_or_bucket,
  input  logic signed [15:0]     in_area_top,
  input  logic signed [15:0]     in_area_right,
  input  logic signed [15:0]     in_area_bottom,
  input  logic signed [15:0]     in_clip_left,
  input  logic signed [15:0]     in_clip_top,
  input  logic signed [15:0]     in_clip_right,
  input  logic signed [15:0]     in_clip_bottom,
  output logic [4:0]             out_scene_tag,
  output logic                   out_counted,
  output logic [2:0]             out_size_class,
  output logic [32:0]            out_visible_pixels,
  output logic                   out_scene_used,
  output logic [31:0]            out_task_total,
  output logic [63:0]            out_pixel_total
);
  import dtah_pkg::*;

  localparam int BASE_DEPTH = SCENES * TYPES * RENDERERS;
  localparam int DEPTH      = BASE_DEPTH * BUCKETS;
  localparam int BASE_W     = $clog2(BASE_DEPTH);
  localparam int ADDR_W     = BASE_W + BUCKET_W;
  localparam int SC_W       = (SCENES > 1) ? $clog2(SCENES) : 1;
  localparam int AS_W       = $clog2(SCENES + 1);

  // entry store: task count in the low word, pixel sum above
  logic [95:0]          entry_mem_r [DEPTH];
  logic [95:0]          rdata_r;
  logic [ADDR_W-1:0]    sweep_cnt_r;
  logic                 sweep_last;

  // captured request
  logic [2:0]           kind_r;
  logic [7:0]           sc_r;
  logic                 sc_ok_r;
  logic                 entry_ok_r;
  logic                 bk_ok_r;
  logic [BUCKET_W-1:0]  bk_r;
  logic [BASE_W-1:0]    base_r;
  logic [16:0]          w_r;
  logic [16:0]          h_r;
  logic [32:0]          px_r;
  logic [2:0]           cls_r;

  // scene state
  logic [AS_W-1:0]      active_r;
  logic [SCENES-1:0]    scene_flags_r;

  // combinational helpers
  logic signed [15:0]   x1, y1, x2, y2;
  logic signed [16:0]   dx, dy;
  logic                 empty;
  logic                 sc_ok, entry_ok;
  logic [BASE_W-1:0]    base_c;
  logic [32:0]          w_ext, h_ext;
  logic [2:0]           cls_c;
  logic [BUCKET_W-1:0]  look_bk;
  logic [ADDR_W-1:0]    look_addr;
  logic [31:0]          act_ext;

  // clipped rectangle extents
  always_comb begin
    x1 = (in_left_or_bucket > in_clip_left) ? in_left_or_bucket : in_clip_left;
    y1 = (in_area_top > in_clip_top) ? in_area_top : in_clip_top;
    x2 = (in_area_right < in_clip_right) ? in_area_right : in_clip_right;
    y2 = (in_area_bottom < in_clip_bottom) ? in_area_bottom : in_clip_bottom;
    empty = (x1 > x2) || (y1 > y2);
    dx = {x2[15], x2} - {x1[15], x1} + 17'sd1;
    dy = {y2[15], y2} - {y1[15], y1} + 17'sd1;
  end

  // index range checks and entry row base
  assign sc_ok    = in_scene < 8'(SCENES);
  assign entry_ok = sc_ok && (in_draw_type < 8'(TYPES)) && (in_renderer < 8'(RENDERERS));
  assign base_c   = BASE_W'((32'(in_scene) * 32'(TYPES) + 32'(in_draw_type))
                    * 32'(RENDERERS) + 32'(in_renderer));

  // capture, multiply and class
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_kind;
      sc_r       <= in_scene;
      sc_ok_r    <= sc_ok;
      entry_ok_r <= entry_ok;
      bk_ok_r    <= (in_left_or_bucket[15:BUCKET_W] == '0);
      bk_r       <= in_left_or_bucket[BUCKET_W-1:0];
      base_r     <= base_c;
      w_r        <= empty ? 17'd0 : dx;
      h_r        <= empty ? 17'd0 : dy;
    end
    if (cmd.mul_en) begin
      px_r <= w_ext * h_ext;
    end
    if (cmd.look_en) begin
      cls_r <= cls_c;
    end
  end

  assign w_ext = 33'(w_r);
  assign h_ext = 33'(h_r);

  // lookup address: read uses the given bucket, execute its class
  assign cls_c     = size_class_of(px_r);
  assign look_bk   = (kind_r == KIND_READ) ? bk_r : cls_c;
  assign look_addr = {base_r, look_bk};

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_en) begin
      sweep_cnt_r <= sweep_last ? '0 : sweep_cnt_r + 1'b1;
    end
  end

  assign sweep_last = (sweep_cnt_r == ADDR_W'(DEPTH - 1));

  // entry store port
  always_ff @(posedge clk) begin
    if (cmd.look_en) begin
      rdata_r <= entry_mem_r[look_addr];
    end
    if (cmd.sweep_en) begin
      entry_mem_r[sweep_cnt_r] <= '0;
    end else if (cmd.post_en && kind_r == KIND_EXEC && entry_ok_r) begin
      entry_mem_r[{base_r, cls_r}] <= {rdata_r[95:32] + 64'(px_r), rdata_r[31:0] + 32'd1};
    end
  end

  // current scene and used flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= AS_W'(SCENES);
      scene_flags_r <= '0;
    end else if (cmd.post_en) begin
      case (kind_r)
        KIND_CLEAR: begin
          active_r      <= AS_W'(SCENES);
          scene_flags_r <= '0;
        end
        KIND_BEGIN: begin
          if (sc_ok_r) begin
            active_r                    <= AS_W'(sc_r);
            scene_flags_r[sc_r[SC_W-1:0]] <= 1'b1;
          end else begin
            active_r <= AS_W'(SCENES);
          end
        end
        KIND_END: begin
          active_r <= AS_W'(SCENES);
        end
        default: begin
        end
      endcase
    end
  end

  assign act_ext = 32'(active_r);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.post_en) begin
      out_scene_tag      <= (kind_r == KIND_TAG) ? act_ext[4:0] : 5'd0;
      out_counted        <= (kind_r == KIND_EXEC) && entry_ok_r;
      out_size_class     <= (kind_r == KIND_EXEC) ? cls_r : 3'd0;
      out_visible_pixels <= (kind_r == KIND_EXEC) ? px_r : 33'd0;
      out_scene_used     <= (kind_r == KIND_READ) && sc_ok_r
                            && scene_flags_r[sc_r[SC_W-1:0]];
      out_task_total     <= ((kind_r == KIND_READ) && entry_ok_r && bk_ok_r)
                            ? rdata_r[31:0] : 32'd0;
      out_pixel_total    <= ((kind_r == KIND_READ) && entry_ok_r && bk_ok_r)
                            ? rdata_r[95:32] : 64'd0;
    end
  end

  assign status.kind       = kind_r;
  assign status.sweep_last = sweep_last;

endmodule

// ----- sv/dtah_ctrl.sv -----
`include "draw_task_area_histogram_assert.svh"

module dtah_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [2:0]             in_kind,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  dtah_pkg::dtah_status_t status,
  output dtah_pkg::dtah_cmd_t    cmd
);
  import dtah_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_LOOK,
    ST_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_kind == KIND_EXEC) state_nxt = ST_MUL;
          else if (in_kind == KIND_READ) state_nxt = ST_LOOK;
          else state_nxt = ST_POST;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look_en = 1'b1;
        state_nxt   = ST_POST;
      end
      ST_POST: begin
        // commit once the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.post_en   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = (status.kind == KIND_CLEAR) ? ST_SWEEP : ST_IDLE;
        end
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `DTAH_ASSERT_NEXT(a_post_shows_result, cmd.post_en, out_valid_r, "result not shown after commit")
  `DTAH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "beat taken while busy")
  `DTAH_ASSERT_NEXT(a_clear_sweeps, cmd.post_en && status.kind == KIND_CLEAR, state_r == ST_SWEEP, "clear without clearing pass")

endmodule

// ----- sv/draw_task_area_histogram.sv -----
// Draw task area histogram. Each input beat is one request (clear, scene begin,
// scene end, tag task, execute task, read entry) and yields exactly one result
// beat. Execute goes through capture, multiply, store lookup and update, read
// skips the multiply and the other kinds go from capture straight to update;
// apart from a clear, the next beat is taken in the cycle after the result
// is committed, and a result waiting in the output register does not block
// the next accept. The counters live in one single-port memory of
// SCENES*TYPES*RENDERERS*8 entries, so after reset and after every clear a
// clearing pass writes one entry per cycle, during which in_ready stays low.
module draw_task_area_histogram #(
  parameter int SCENES    = dtah_pkg::DTAH_SCENES,
  parameter int TYPES     = dtah_pkg::DTAH_TYPES,
  parameter int RENDERERS = dtah_pkg::DTAH_RENDERERS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_scene,
  input  logic [7:0]         in_draw_type,
  input  logic [7:0]         in_renderer,
  input  logic signed [15:0] in_left_or_bucket,
  input  logic signed [15:0] in_area_top,
  input  logic signed [15:0] in_area_right,
  input  logic signed [15:0] in_area_bottom,
  input  logic signed [15:0] in_clip_left,
  input  logic signed [15:0] in_clip_top,
  input  logic signed [15:0] in_clip_right,
  input  logic signed [15:0] in_clip_bottom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_scene_tag,
  output logic               out_counted,
  output logic [2:0]         out_size_class,
  output logic [32:0]        out_visible_pixels,
  output logic               out_scene_used,
  output logic [31:0]        out_task_total,
  output logic [63:0]        out_pixel_total
);
  import dtah_pkg::*;

  dtah_cmd_t    cmd;
  dtah_status_t status;

  // sequencer
  dtah_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // store, scene state and result register
  dtah_datapath #(
    .SCENES    (SCENES),
    .TYPES     (TYPES),
    .RENDERERS (RENDERERS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (in_kind),
    .in_scene           (in_scene),
    .in_draw_type       (in_draw_type),
    .in_renderer        (in_renderer),
    .in_left_or_bucket  (in_left_or_bucket),
    .in_area_top        (in_area_top),
    .in_area_right      (in_area_right),
    .in_area_bottom     (in_area_bottom),
    .in_clip_left       (in_clip_left),
    .in_clip_top        (in_clip_top),
    .in_clip_right      (in_clip_right),
    .in_clip_bottom     (in_clip_bottom),
    .out_scene_tag      (out_scene_tag),
    .out_counted        (out_counted),
    .out_size_class     (out_size_class),
    .out_visible_pixels (out_visible_pixels),
    .out_scene_used     (out_scene_used),
    .out_task_total     (out_task_total),
    .out_pixel_total    (out_pixel_total)
  );

endmodule

// ----- tb/tb_draw_task_area_histogram.sv -----
`timescale 1ns / 100ps

module tb_draw_task_area_histogram;
  import dtah_pkg::*;

  localparam int N_SCENES    = DTAH_SCENES;
  localparam int N_TYPES     = DTAH_TYPES;
  localparam int N_RENDERERS = DTAH_RENDERERS;
  localparam int N_ENTRIES   = N_SCENES * N_TYPES * N_RENDERERS * BUCKETS;
  localparam logic [4:0] NO_SCENE = 5'(N_SCENES);

  // kinds the block leaves without effect
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 650;
  localparam int PHASE_ITEMS  = 82;
  localparam int DRAIN_CYCLES = 16;
  // the clearing pass after reset or a clear holds in_ready low
  localparam int STALL_LIMIT  = 40000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  scene;
    logic [7:0]  draw_type;
    logic [7:0]  renderer;
    logic [15:0] left_or_bucket;
    logic [15:0] area_top;
    logic [15:0] area_right;
    logic [15:0] area_bottom;
    logic [15:0] clip_left;
    logic [15:0] clip_top;
    logic [15:0] clip_right;
    logic [15:0] clip_bottom;
  } draw_req_t;

  typedef struct packed {
    logic [4:0]  scene_tag;
    logic        counted;
    logic [2:0]  size_class;
    logic [32:0] visible_pixels;
    logic        scene_used;
    logic [31:0] task_total;
    logic [63:0] pixel_total;
  } draw_resp_t;

  typedef struct packed {
    draw_req_t  req;
    logic       typed;
    draw_resp_t resp;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] scene;
    logic [7:0] draw_type;
    logic [7:0] renderer;
    logic [2:0] bucket;
  } hot_entry_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_kind;
  logic [7:0]         in_scene;
  logic [7:0]         in_draw_type;
  logic [7:0]         in_renderer;
  logic signed [15:0] in_left_or_bucket;
  logic signed [15:0] in_area_top;
  logic signed [15:0] in_area_right;
  logic signed [15:0] in_area_bottom;
  logic signed [15:0] in_clip_left;
  logic signed [15:0] in_clip_top;
  logic signed [15:0] in_clip_right;
  logic signed [15:0] in_clip_bottom;
  logic               out_valid;
  logic               out_ready;
  logic [4:0]         out_scene_tag;
  logic               out_counted;
  logic [2:0]         out_size_class;
  logic [32:0]        out_visible_pixels;
  logic               out_scene_used;
  logic [31:0]        out_task_total;
  logic [63:0]        out_pixel_total;

  // shadow copy of the histogram store
  logic [31:0] task_tally  [N_ENTRIES];
  logic [63:0] pixel_tally [N_ENTRIES];
  logic        scene_seen  [N_SCENES];
  logic [4:0]  open_scene;

  draw_resp_t expected_replies[$];
  hot_entry_t hot_entries[$];
  stim_row_t  directed_rows[$];

  int fail_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  draw_task_area_histogram dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_scene           (in_scene),
    .in_draw_type       (in_draw_type),
    .in_renderer        (in_renderer),
    .in_left_or_bucket  (in_left_or_bucket),
    .in_area_top        (in_area_top),
    .in_area_right      (in_area_right),
    .in_area_bottom     (in_area_bottom),
    .in_clip_left       (in_clip_left),
    .in_clip_top        (in_clip_top),
    .in_clip_right      (in_clip_right),
    .in_clip_bottom     (in_clip_bottom),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_scene_tag      (out_scene_tag),
    .out_counted        (out_counted),
    .out_size_class     (out_size_class),
    .out_visible_pixels (out_visible_pixels),
    .out_scene_used     (out_scene_used),
    .out_task_total     (out_task_total),
    .out_pixel_total    (out_pixel_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic draw_req_t mk_req(logic [2:0] kind, int sc, int ty, int rd, int lb, int at,
                                       int ar, int ab, int cl, int ct, int cr, int cb);
    draw_req_t r;
    r.kind           = kind;
    r.scene          = 8'(sc);
    r.draw_type      = 8'(ty);
    r.renderer       = 8'(rd);
    r.left_or_bucket = 16'(lb);
    r.area_top       = 16'(at);
    r.area_right     = 16'(ar);
    r.area_bottom    = 16'(ab);
    r.clip_left      = 16'(cl);
    r.clip_top       = 16'(ct);
    r.clip_right     = 16'(cr);
    r.clip_bottom    = 16'(cb);
    return r;
  endfunction

  function automatic draw_resp_t mk_resp(logic [4:0] tag, logic cnt, logic [2:0] cls,
                                         logic [32:0] px, logic used, logic [31:0] tasks,
                                         logic [63:0] pixels);
    draw_resp_t p;
    p.scene_tag      = tag;
    p.counted        = cnt;
    p.size_class     = cls;
    p.visible_pixels = px;
    p.scene_used     = used;
    p.task_total     = tasks;
    p.pixel_total    = pixels;
    return p;
  endfunction

  function automatic void wipe_histogram();
    for (int i = 0; i < N_ENTRIES; i++) begin
      task_tally[i]  = '0;
      pixel_tally[i] = '0;
    end
    for (int i = 0; i < N_SCENES; i++) scene_seen[i] = 1'b0;
    open_scene = NO_SCENE;
  endfunction

  // power-of-four class: 0, then up to 64, 256, ... 65536, then the rest
  function automatic logic [2:0] area_class(longint unsigned px);
    longint unsigned lim;
    if (px == 0) return 3'd0;
    lim = 64;
    for (int c = 1; c < 7; c++) begin
      if (px <= lim) return 3'(c);
      lim = lim * 4;
    end
    return 3'd7;
  endfunction

  function automatic int entry_of(int sc, int ty, int rd, int bk);
    return ((sc * N_TYPES + ty) * N_RENDERERS + rd) * BUCKETS + bk;
  endfunction

  // apply one request to the shadow store and return the reply it causes
  function automatic draw_resp_t histogram_apply(draw_req_t r);
    draw_resp_t      rsp;
    int              x1, y1, x2, y2, e;
    longint unsigned px;
    logic            in_store;
    rsp = '0;
    in_store = (r.scene < N_SCENES) && (r.draw_type < N_TYPES) && (r.renderer < N_RENDERERS);
    case (r.kind)
      KIND_CLEAR: wipe_histogram();
      KIND_BEGIN: begin
        if (r.scene < N_SCENES) begin
          scene_seen[r.scene] = 1'b1;
          open_scene = 5'(r.scene);
        end else begin
          open_scene = NO_SCENE;
        end
      end
      KIND_END: open_scene = NO_SCENE;
      KIND_TAG: rsp.scene_tag = open_scene;
      KIND_EXEC: begin
        // inclusive-corner intersection of draw and clip rectangles
        x1 = ($signed(r.left_or_bucket) > $signed(r.clip_left)) ?
             $signed(r.left_or_bucket) : $signed(r.clip_left);
        y1 = ($signed(r.area_top) > $signed(r.clip_top)) ?
             $signed(r.area_top) : $signed(r.clip_top);
        x2 = ($signed(r.area_right) < $signed(r.clip_right)) ?
             $signed(r.area_right) : $signed(r.clip_right);
        y2 = ($signed(r.area_bottom) < $signed(r.clip_bottom)) ?
             $signed(r.area_bottom) : $signed(r.clip_bottom);
        if (x1 > x2 || y1 > y2) px = 0;
        else px = longint'(x2 - x1 + 1) * longint'(y2 - y1 + 1);
        rsp.size_class     = area_class(px);
        rsp.visible_pixels = 33'(px);
        if (in_store) begin
          e = entry_of(r.scene, r.draw_type, r.renderer, rsp.size_class);
          task_tally[e]  = task_tally[e] + 32'd1;
          pixel_tally[e] = pixel_tally[e] + 64'(px);
          rsp.counted    = 1'b1;
        end
      end
      KIND_READ: begin
        if (r.scene < N_SCENES) begin
          rsp.scene_used = scene_seen[r.scene];
          if (in_store && r.left_or_bucket < BUCKETS) begin
            e = entry_of(r.scene, r.draw_type, r.renderer, r.left_or_bucket);
            rsp.task_total  = task_tally[e];
            rsp.pixel_total = pixel_tally[e];
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // random span of width 1..2^k placed inside the 16-bit signed range
  function automatic void random_span(output logic [15:0] lo, output logic [15:0] hi);
    int w, x0;
    w  = $urandom_range(1, 1 << $urandom_range(0, 16));
    x0 = -32768 + $urandom_range(0, 65536 - w);
    lo = 16'(x0);
    hi = 16'(x0 + w - 1);
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t    r;
    hot_entry_t   h;
    int           pick;
    logic [191:0] noise;
    // every field random first, relevant ones narrowed below
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(draw_req_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 1) r.kind = KIND_CLEAR;
    else if (pick < 9) r.kind = KIND_BEGIN;
    else if (pick < 14) r.kind = KIND_END;
    else if (pick < 21) r.kind = KIND_TAG;
    else if (pick < 65) r.kind = KIND_EXEC;
    else if (pick < 96) r.kind = KIND_READ;
    else r.kind = ($urandom_range(1) != 0) ? KIND_SPARE6 : KIND_SPARE7;
    // noise: leave the fields fully random
    if ($urandom_range(99) < 10) return r;
    case (r.kind)
      KIND_BEGIN: begin
        if ($urandom_range(99) < 85) r.scene = 8'($urandom_range(N_SCENES - 1));
      end
      KIND_EXEC: begin
        // few scenes so entries are hit repeatedly
        r.scene = ($urandom_range(99) < 60) ? 8'($urandom_range(3)) :
                  8'($urandom_range(N_SCENES - 1));
        if ($urandom_range(99) < 90) r.draw_type = 8'($urandom_range(N_TYPES - 1));
        if ($urandom_range(99) < 90) r.renderer = 8'($urandom_range(N_RENDERERS - 1));
        if ($urandom_range(99) < 85) begin
          random_span(r.left_or_bucket, r.area_right);
          random_span(r.area_top, r.area_bottom);
          if ($urandom_range(1) != 0) begin
            r.clip_left   = 16'h8000;
            r.clip_top    = 16'h8000;
            r.clip_right  = 16'h7fff;
            r.clip_bottom = 16'h7fff;
          end else begin
            random_span(r.clip_left, r.clip_right);
            random_span(r.clip_top, r.clip_bottom);
          end
        end
      end
      KIND_READ: begin
        if (hot_entries.size() != 0 && $urandom_range(99) < 65) begin
          h = hot_entries[$urandom_range(hot_entries.size() - 1)];
          r.scene          = h.scene;
          r.draw_type      = h.draw_type;
          r.renderer       = h.renderer;
          r.left_or_bucket = 16'(h.bucket);
        end else begin
          r.scene = 8'($urandom_range(N_SCENES - 1));
          if ($urandom_range(99) < 90) r.draw_type = 8'($urandom_range(N_TYPES - 1));
          if ($urandom_range(99) < 90) r.renderer = 8'($urandom_range(N_RENDERERS - 1));
          if ($urandom_range(99) < 80) r.left_or_bucket = 16'($urandom_range(BUCKETS - 1));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // present one request beat and record its reply once accepted
  task automatic send_item(draw_req_t r, logic typed, draw_resp_t want);
    draw_resp_t pred;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_kind           = r.kind;
    in_scene          = r.scene;
    in_draw_type      = r.draw_type;
    in_renderer       = r.renderer;
    in_left_or_bucket = r.left_or_bucket;
    in_area_top       = r.area_top;
    in_area_right     = r.area_right;
    in_area_bottom    = r.area_bottom;
    in_clip_left      = r.clip_left;
    in_clip_top       = r.clip_top;
    in_clip_right     = r.clip_right;
    in_clip_bottom    = r.clip_bottom;
    do @(posedge clk); while (!in_ready);
    pred = histogram_apply(r);
    expected_replies.push_back(typed ? want : pred);
    if (pred.counted) begin
      hot_entries.push_back({r.scene, r.draw_type, r.renderer, pred.size_class});
      if (hot_entries.size() > 32) void'(hot_entries.pop_front());
    end
  endtask

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // reply checker
  always @(posedge clk) begin : reply_check
    draw_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        if (fail_count < REPORT_MAX) $display("unexpected reply beat at %0t", $realtime);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_scene_tag !== want.scene_tag || out_counted !== want.counted ||
            out_size_class !== want.size_class || out_visible_pixels !== want.visible_pixels ||
            out_scene_used !== want.scene_used || out_task_total !== want.task_total ||
            out_pixel_total !== want.pixel_total) begin
          if (fail_count < REPORT_MAX) begin
            $display("reply mismatch at %0t", $realtime);
            $display("  exp tag=%0d cnt=%0d cls=%0d px=%0d used=%0d tasks=%0d pix=%0d",
                     want.scene_tag, want.counted, want.size_class, want.visible_pixels,
                     want.scene_used, want.task_total, want.pixel_total);
            $display("  got tag=%0d cnt=%0d cls=%0d px=%0d used=%0d tasks=%0d pix=%0d",
                     out_scene_tag, out_counted, out_size_class, out_visible_pixels,
                     out_scene_used, out_task_total, out_pixel_total);
          end
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    draw_req_t r;
    int        sent;
    int        phase;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_kind           = '0;
    in_scene          = '0;
    in_draw_type      = '0;
    in_renderer       = '0;
    in_left_or_bucket = '0;
    in_area_top       = '0;
    in_area_right     = '0;
    in_area_bottom    = '0;
    in_clip_left      = '0;
    in_clip_top       = '0;
    in_clip_right     = '0;
    in_clip_bottom    = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    wipe_histogram();

    // directed rows: typed replies where they are obvious, else predicted
    directed_rows.push_back('{mk_req(KIND_TAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(NO_SCENE, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_BEGIN, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_TAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(5'd3, 0, 0, 0, 0, 0, 0)});
    // full-range draw and clip: 2^32 pixels, top class
    directed_rows.push_back('{mk_req(KIND_EXEC, 3, 12, 2, -32768, -32768, 32767, 32767,
                                     -32768, -32768, 32767, 32767), 1'b1,
                              mk_resp(0, 1, 3'd7, 33'h1_0000_0000, 0, 0, 0)});
    // disjoint rectangles count with zero pixels
    directed_rows.push_back('{mk_req(KIND_EXEC, 3, 0, 0, 10, 10, 20, 20, 30, 0, 40, 40), 1'b1,
                              mk_resp(0, 1, 3'd0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(KIND_EXEC, 3, 0, 0, 0, 0, 7, 7, -100, -100, 100, 100),
                              1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_EXEC, 15, 12, 2, 0, 0, 255, 255, -32768, -32768,
                                     32767, 32767), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_EXEC, 15, 12, 2, 0, 0, 256, 255, -32768, -32768,
                                     32767, 32767), 1'b0, '0});
    // out-of-range indexes are dropped but still report the area
    directed_rows.push_back('{mk_req(KIND_EXEC, 3, 13, 0, 0, 0, 9, 9, 0, 0, 9, 9), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_EXEC, 16, 0, 3, 0, 0, 99, 3, 0, 0, 99, 3), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_EXEC, 255, 255, 255, 32767, 32767, -32768, -32768,
                                     32767, 32767, -32768, -32768), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_READ, 3, 12, 2, 7, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(0, 0, 0, 0, 1, 1, 64'h1_0000_0000)});
    directed_rows.push_back('{mk_req(KIND_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // bucket taken as unsigned, so all-ones is out of range
    directed_rows.push_back('{mk_req(KIND_READ, 3, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_READ, 255, 255, 255, -32768, -1, -1, -1, -1, -1, -1,
                                     -1), 1'b1, '0});
    // begin with a scene out of range leaves no open scene
    directed_rows.push_back('{mk_req(KIND_BEGIN, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_TAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(NO_SCENE, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(KIND_BEGIN, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_TAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(5'd15, 0, 0, 0, 0, 0, 0)});
    directed_rows.push_back('{mk_req(KIND_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_TAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_resp(NO_SCENE, 0, 0, 0, 0, 0, 0)});
    // spare kinds reply with all zero
    directed_rows.push_back('{mk_req(KIND_SPARE6, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1),
                              1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    // clear wipes counters and used flags
    directed_rows.push_back('{mk_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    directed_rows.push_back('{mk_req(KIND_READ, 3, 12, 2, 7, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp);

    // random part, rotating through the idling phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = (sent / PHASE_ITEMS) % 4;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      r = random_request();
      send_item(r, 1'b0, '0);
      if (r.kind != KIND_SPARE6 && r.kind != KIND_SPARE7) sent++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
